### design/calendar_date_step_assert.svh
// Assertion macros used by the date stepper checker.
// Needs clk and arst_n in the scope of each use.
`ifndef CALENDAR_DATE_STEP_ASSERT_SVH
`define CALENDAR_DATE_STEP_ASSERT_SVH

// same-cycle implication
`define CDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/cds_pkg.sv
// Types, constants and month tables for the Gregorian date stepper.
// No dependencies.
package cds_pkg;

	localparam logic [3:0]  MONTH_JAN = 4'd1;
	localparam logic [3:0]  MONTH_FEB = 4'd2;
	localparam logic [3:0]  MONTH_DEC = 4'd12;
	localparam logic [4:0]  DAY_FIRST = 5'd1;
	localparam logic [4:0]  DEC_LEN   = 5'd31;
	localparam logic [13:0] YEAR_MIN  = 14'd1;
	localparam logic [13:0] YEAR_MAX  = 14'd9999;

	// y / 25 == (y * 20972) >> 19 for every 14-bit y
	localparam logic [14:0] DIV25_MULT  = 15'd20972;
	localparam int          DIV25_SHIFT = 19;
	localparam int          PROD_W      = 29;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
	} cds_in_t;

	typedef struct packed {
		logic [4:0]  next_day;
		logic [3:0]  next_month;
		logic [13:0] next_year;
		logic [4:0]  prev_day;
		logic [3:0]  prev_month;
		logic [13:0] prev_year;
		logic [8:0]  ordinal_day;
		logic        date_valid;
	} cds_out_t;

	function automatic logic [4:0] cds_month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                        len = leap ? 5'd29 : 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] cds_days_before(input logic [3:0] m);
		logic [8:0] days;
		case (m)
			4'd1:    days = 9'd0;
			4'd2:    days = 9'd31;
			4'd3:    days = 9'd59;
			4'd4:    days = 9'd90;
			4'd5:    days = 9'd120;
			4'd6:    days = 9'd151;
			4'd7:    days = 9'd181;
			4'd8:    days = 9'd212;
			4'd9:    days = 9'd243;
			4'd10:   days = 9'd273;
			4'd11:   days = 9'd304;
			4'd12:   days = 9'd334;
			default: days = 9'd0;
		endcase
		return days;
	endfunction

endpackage

### design/calendar_date_step.sv
// Gregorian date stepper: next date, previous date and day of year.
// Depends on cds_pkg.
//
//  channel | direction | handshake             | word
//  req     | in        | req_valid / req_ready | cds_in_t  (day, month, year)
//  rsp     | out       | rsp_valid / rsp_ready | cds_out_t (next, prev, ordinal, valid)
//
// Three register stages: year * reciprocal, leap and month lengths, result register.
// One word a cycle while rsp_ready allows; rsp_valid rises once the word reaches the result register.
// Reset clears the stage valid bits only.
// A stall holds the result register and each occupied stage directly behind it; empty stages still fill.
module calendar_date_step
	import cds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  cds_in_t  req_word,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output cds_out_t rsp_word
);

	logic adv1, adv2, adv3;
	logic v_s1, v_s2, v_s3;

	// stage 1
	cds_in_t            date_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic [PROD_W-1:0]  prod;

	// stage 2
	cds_in_t     date_s2;
	logic        leap_s2;
	logic        ok_s2;
	logic [4:0]  cur_len_s2;
	logic [4:0]  prev_len_s2;
	logic [9:0]  quot;
	logic [13:0] quot25;
	logic        div25;
	logic        leap;
	logic        month_ok;
	logic        year_ok;
	logic [4:0]  cur_len;
	logic [4:0]  prev_len;
	logic [3:0]  month_before;

	// stage 3
	cds_out_t res;
	cds_out_t res_s3;

	assign adv3      = !v_s3 || rsp_ready;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign req_ready = adv1;
	assign rsp_valid = v_s3;
	assign rsp_word  = res_s3;

	assign prod = PROD_W'(req_word.year) * PROD_W'(DIV25_MULT);

	always_comb begin
		quot         = prod_s1[PROD_W-1:DIV25_SHIFT];
		quot25       = 14'({quot, 4'b0000}) + 14'({quot, 3'b000}) + 14'(quot);
		div25        = (date_s1.year == quot25);
		leap         = (date_s1.year[1:0] == 2'b00) && (!div25 || (date_s1.year[3:2] == 2'b00));
		month_ok     = (date_s1.month >= MONTH_JAN) && (date_s1.month <= MONTH_DEC);
		year_ok      = (date_s1.year >= YEAR_MIN) && (date_s1.year <= YEAR_MAX);
		month_before = date_s1.month - 4'd1;
		cur_len      = cds_month_len(date_s1.month, leap);
		prev_len     = cds_month_len(month_before, leap);
	end

	always_comb begin
		res = '0;
		if (ok_s2) begin
			res.date_valid = 1'b1;
			res.next_day   = date_s2.day;
			res.next_month = date_s2.month;
			res.next_year  = date_s2.year;
			res.prev_day   = date_s2.day;
			res.prev_month = date_s2.month;
			res.prev_year  = date_s2.year;
			if (date_s2.day < cur_len_s2) begin
				res.next_day = date_s2.day + 5'd1;
			end else begin
				res.next_day = DAY_FIRST;
				if (date_s2.month < MONTH_DEC) begin
					res.next_month = date_s2.month + 4'd1;
				end else begin
					res.next_month = MONTH_JAN;
					res.next_year  = date_s2.year + 14'd1;
				end
			end
			if (date_s2.day > DAY_FIRST) begin
				res.prev_day = date_s2.day - 5'd1;
			end else if (date_s2.month > MONTH_JAN) begin
				res.prev_month = date_s2.month - 4'd1;
				res.prev_day   = prev_len_s2;
			end else begin
				res.prev_month = MONTH_DEC;
				res.prev_year  = date_s2.year - 14'd1;
				res.prev_day   = DEC_LEN;
			end
			res.ordinal_day = cds_days_before(date_s2.month) + 9'(date_s2.day)
				+ 9'(leap_s2 && (date_s2.month > MONTH_FEB));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= req_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			date_s1 <= req_word;
			prod_s1 <= prod;
		end
		if (adv2) begin
			date_s2     <= date_s1;
			leap_s2     <= leap;
			ok_s2       <= month_ok && year_ok && (date_s1.day >= DAY_FIRST)
				&& (date_s1.day <= cur_len);
			cur_len_s2  <= cur_len;
			prev_len_s2 <= prev_len;
		end
		if (adv3) begin
			res_s3 <= res;
		end
	end

endmodule

### design/cds_checker.sv
// Port-level checks for calendar_date_step, attached by bind.
// Depends on cds_pkg and calendar_date_step_assert.svh.
`include "calendar_date_step_assert.svh"

module cds_checker
	import cds_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input cds_out_t rsp_word
);

	`CDS_ASSERT_NOW(a_invalid_zero, rsp_valid && !rsp_word.date_valid,
		$countones(rsp_word) == 0, "invalid date word carries non-zero fields")
	`CDS_ASSERT_NOW(a_valid_days, rsp_valid && rsp_word.date_valid,
		(rsp_word.next_day != 5'd0) && (rsp_word.prev_day != 5'd0)
		&& (rsp_word.ordinal_day != 9'd0) && (rsp_word.ordinal_day <= 9'd366),
		"valid date word has day out of range")
	`CDS_ASSERT_NOW(a_valid_months, rsp_valid && rsp_word.date_valid,
		(rsp_word.next_month >= MONTH_JAN) && (rsp_word.next_month <= MONTH_DEC)
		&& (rsp_word.prev_month >= MONTH_JAN) && (rsp_word.prev_month <= MONTH_DEC),
		"valid date word has month out of range")
	`CDS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word),
		"stalled result word changed")
	`CDS_ASSERT_NOW(a_ready_when_idle, !rsp_valid, req_ready,
		"input not ready with no result word waiting")

endmodule

bind calendar_date_step cds_checker u_cds_checker (.*);

### verif/tb_calendar_date_step.sv
// Self-checking testbench for calendar_date_step: next date, previous date and day of year.
// Drives dates over the valid/ready request channel and checks every response word in order.
// Depends on cds_pkg and calendar_date_step.
module tb_calendar_date_step;
	import cds_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 32;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	cds_in_t  req_word;
	logic     rsp_valid;
	logic     rsp_ready;
	cds_out_t rsp_word;

	cds_out_t pending_dates[$];
	int       error_count;
	int       words_checked;
	int       real_dates;
	int       bad_dates;
	int       cycle_count;
	int       stall_left;
	bit       sender_idles;
	bit       receiver_idles;

	int month_days[12]  = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	int days_ahead[12]  = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	calendar_date_step u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic bit is_leap_year(input int y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int month_length(input int m, input int y);
		if (m == 2 && is_leap_year(y))
			return 29;
		return month_days[m - 1];
	endfunction

	function automatic cds_out_t step_date(input cds_in_t w);
		cds_out_t r;
		int d, m, y, nd, nm, ny, pd, pm, py, ord;
		d = w.day;
		m = w.month;
		y = w.year;
		r = '0;
		if (m < 1 || m > 12 || y < 1 || y > YEAR_MAX)
			return r;
		if (d < 1 || d > month_length(m, y))
			return r;
		nd = d + 1;
		nm = m;
		ny = y;
		if (d == month_length(m, y)) begin
			nd = 1;
			nm = (m == 12) ? 1 : m + 1;
			ny = (m == 12) ? y + 1 : y;
		end
		pd = d - 1;
		pm = m;
		py = y;
		if (d == 1 && m > 1) begin
			pm = m - 1;
			pd = month_length(pm, y);
		end else if (d == 1) begin
			pm = 12;
			pd = 31;
			py = y - 1;
		end
		ord = days_ahead[m - 1] + d + ((m > 2 && is_leap_year(y)) ? 1 : 0);
		r.next_day    = 5'(nd);
		r.next_month  = 4'(nm);
		r.next_year   = 14'(ny);
		r.prev_day    = 5'(pd);
		r.prev_month  = 4'(pm);
		r.prev_year   = 14'(py);
		r.ordinal_day = 9'(ord);
		r.date_valid  = 1'b1;
		return r;
	endfunction

	// mostly real dates weighted to month ends, month starts, century and edge years; the rest malformed
	function automatic cds_in_t pick_date();
		cds_in_t w;
		int odd_years[8] = '{1, 4, 100, 400, 1900, 2000, 2100, 9999};
		int roll, y, m, len;
		roll = $urandom_range(99);
		if (roll < 12) begin
			w.day   = 5'($urandom);
			w.month = 4'($urandom);
			w.year  = 14'($urandom);
			return w;
		end
		y = ($urandom_range(99) < 20) ? odd_years[$urandom_range(7)] : $urandom_range(1, 9999);
		m = $urandom_range(1, 12);
		len = month_length(m, y);
		w.month = 4'(m);
		w.year  = 14'(y);
		if (roll < 18)
			w.day = 5'($urandom_range(len + 1, 31));
		else if (roll < 35)
			w.day = ($urandom_range(1)) ? 5'(len) : DAY_FIRST;
		else
			w.day = 5'($urandom_range(1, len));
		return w;
	endfunction

	task automatic send_date(input cds_in_t w);
		if (sender_idles)
			while ($urandom_range(99) < IDLE_PCT) begin
				req_valid <= 1'b0;
				@(posedge clk);
			end
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic send_dmy(input int d, input int m, input int y);
		cds_in_t w;
		w.day   = 5'(d);
		w.month = 4'(m);
		w.year  = 14'(y);
		send_date(w);
	endtask

	task automatic test_directed();
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		send_dmy(1, 1, 1);
		send_dmy(31, 12, 9999);
		send_dmy(31, 12, 2023);
		send_dmy(1, 1, 2024);
		send_dmy(29, 2, 2024);
		send_dmy(28, 2, 2023);
		send_dmy(29, 2, 2023);
		send_dmy(29, 2, 1900);
		send_dmy(28, 2, 1900);
		send_dmy(29, 2, 2000);
		send_dmy(1, 3, 2000);
		send_dmy(1, 3, 1900);
		send_dmy(31, 1, 2024);
		send_dmy(1, 5, 2021);
		send_dmy(30, 4, 2021);
		send_dmy(31, 4, 2021);
		send_dmy(15, 0, 2021);
		send_dmy(15, 13, 2021);
		send_dmy(0, 6, 2021);
		send_dmy(31, 1, 0);
		send_dmy(1, 1, 10000);
		send_dmy(31, 15, 16383);
		send_dmy(0, 0, 0);
		send_dmy(15, 6, 5000);
		send_dmy(31, 12, 2400);
	endtask

	task automatic test_random_dates(input int n);
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		repeat (n) send_date(pick_date());
	endtask

	task automatic test_full_rate(input int n);
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		repeat (n) send_date(pick_date());
	endtask

	task automatic test_backpressure(input int n);
		sender_idles   = 1'b0;
		receiver_idles = 1'b1;
		stall_left     = 300;
		repeat (n) send_date(pick_date());
	endtask

	always @(posedge clk) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else if (receiver_idles)
			rsp_ready <= ($urandom_range(99) >= IDLE_PCT);
		else
			rsp_ready <= 1'b1;
	end

	always @(posedge clk) begin : check_words
		cds_out_t want;
		cds_out_t got;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				got = rsp_word;
				if (pending_dates.size() == 0) begin
					$error("response word with no date outstanding");
					error_count++;
				end else begin
					want = pending_dates.pop_front();
					words_checked++;
					if (got.next_day !== want.next_day) begin
						$error("next_day: expected %0d, got %0d", want.next_day, got.next_day);
						error_count++;
					end
					if (got.next_month !== want.next_month) begin
						$error("next_month: expected %0d, got %0d", want.next_month,
							got.next_month);
						error_count++;
					end
					if (got.next_year !== want.next_year) begin
						$error("next_year: expected %0d, got %0d", want.next_year, got.next_year);
						error_count++;
					end
					if (got.prev_day !== want.prev_day) begin
						$error("prev_day: expected %0d, got %0d", want.prev_day, got.prev_day);
						error_count++;
					end
					if (got.prev_month !== want.prev_month) begin
						$error("prev_month: expected %0d, got %0d", want.prev_month,
							got.prev_month);
						error_count++;
					end
					if (got.prev_year !== want.prev_year) begin
						$error("prev_year: expected %0d, got %0d", want.prev_year, got.prev_year);
						error_count++;
					end
					if (got.ordinal_day !== want.ordinal_day) begin
						$error("ordinal_day: expected %0d, got %0d", want.ordinal_day,
							got.ordinal_day);
						error_count++;
					end
					if (got.date_valid !== want.date_valid) begin
						$error("date_valid: expected %0d, got %0d", want.date_valid,
							got.date_valid);
						error_count++;
					end
				end
			end
			if (req_valid && req_ready) begin
				want = step_date(req_word);
				if (want.date_valid)
					real_dates++;
				else
					bad_dates++;
				pending_dates.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				pending_dates.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req_word       = '0;
		rsp_ready      = 1'b0;
		error_count    = 0;
		words_checked  = 0;
		real_dates     = 0;
		bad_dates      = 0;
		cycle_count    = 0;
		stall_left     = 0;
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_dates(500);
		test_full_rate(150);
		test_backpressure(100);

		req_valid <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d response words checked: %0d real dates, %0d malformed or out of range",
			words_checked, real_dates, bad_dates);
		$display("covered month and year roll-over, leap rules, idle gaps and a long output stall");
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/cds_pkg.sv
design/calendar_date_step.sv
design/cds_checker.sv
verif/tb_calendar_date_step.sv
